>>> src/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u2u_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   typedef enum logic [1:0] {
      STATUS_UNIT = 2'd0,
      STATUS_OK   = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   localparam logic [7:0]  ASCII_MAX     = 8'h7F;
   localparam logic [7:0]  CONT_MAX      = 8'hBF;
   localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
   localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
   localparam logic [7:0]  LEAD4_MAX     = 8'hF7;
   localparam logic [20:0] SURR_LOW      = 21'h00D800;
   localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
   localparam logic [20:0] CODE_MAX      = 21'h10FFFF;
   localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h010000;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

   // One decoded byte: up to two code units, optionally followed by an end marker.
   typedef struct packed {
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic [1:0]  unit_count;
      logic        has_marker;
      logic        marker_err;
   } entry_type;

endpackage
`default_nettype wire

>>> src/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 transcoder: the front decoder, entry queue and result sequencer.
//
// The request channel takes one UTF-8 byte per request in req_tdata, with
// req_tlast on the final byte of a string. The response channel returns
// UTF-16 code units in rsp_tdata with rsp_tuser = 0, and one end marker per
// string (rsp_tuser = 1 valid, 2 error, rsp_tdata = 0). rsp_tlast marks the
// final response caused by a request byte. After an error the rest of the
// string is dropped and only the error marker follows at the end byte.
// Each byte's results pass through the queue registers before they are offered.
// One request is taken every cycle while the four-entry queue has room; the
// response side sends one response per cycle while rsp_tready is high, so a
// byte that yields a surrogate pair plus a marker gives up to three responses,
// and bytes that yield nothing (lead and inner continuation bytes) take no
// response slot. When the receiver stalls, the queue fills and req_tready
// drops once four byte results are waiting. Reset is synchronous: it empties
// the queue and clears the decoder, so the next byte starts a new string.
`default_nettype none
module utf8_to_utf16_transcoder_unit import u2u_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] code_unit
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast    // last_of_run
);

   logic      queue_full;
   logic      queue_not_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   u2u_front front_i (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .in_ready   (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   u2u_queue queue_i (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   u2u_back back_i (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_unit   (rsp_tdata),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> src/u2u_front.sv
// Front end: decodes UTF-8 bytes into queue entries of UTF-16 units and end markers.
`default_nettype none
module u2u_front import u2u_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic      in_last,
   input  wire logic      queue_full,
   output logic           in_ready,
   output logic           push,
   output entry_type      push_entry
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic        complete;
   logic        fail_now;
   logic [20:0] cp;
   logic [19:0] offset;
   logic [1:0]  count;
   logic        bad;
   logic [20:0] sum;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      fail_now = 1'b0;
      complete = 1'b0;
      cp       = acc_ff;
      count    = 2'd0;
      offset   = '0;
      sum      = '0;
      push_entry = '0;
      if (!failed_ff) begin
         if (rem_ff == 2'd0) begin
            if (in_byte <= ASCII_MAX) begin
               cp       = {13'd0, in_byte};
               complete = 1'b1;
            end else if (in_byte <= CONT_MAX) begin
               fail_now = 1'b1;
            end else if (in_byte <= LEAD2_MAX) begin
               acc_in = {16'd0, in_byte[4:0]};
               rem_in = 2'd1;
            end else if (in_byte <= LEAD3_MAX) begin
               acc_in = {17'd0, in_byte[3:0]};
               rem_in = 2'd2;
            end else if (in_byte <= LEAD4_MAX) begin
               acc_in = {18'd0, in_byte[2:0]};
               rem_in = 2'd3;
            end else begin
               fail_now = 1'b1;
            end
         end else begin
            if (in_byte < 8'h80 || in_byte > CONT_MAX) begin
               fail_now = 1'b1;
            end else begin
               cp     = {acc_ff[14:0], in_byte[5:0]};
               acc_in = cp;
               rem_in = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  complete = 1'b1;
               end
            end
         end
      end

      if (complete) begin
         acc_in = '0;
         if ((cp >= SURR_LOW && cp <= SURR_HIGH) || cp > CODE_MAX) begin
            fail_now = 1'b1;
         end else if (cp <= BMP_MAX) begin
            count            = 2'd1;
            push_entry.unit0 = cp[15:0];
         end else begin
            // Supplementary plane: split the 20-bit offset into a surrogate pair.
            sum              = cp - SUPP_BASE;
            offset           = sum[19:0];
            count            = 2'd2;
            push_entry.unit0 = HIGH_SURR_BASE | {6'd0, offset[19:10]};
            push_entry.unit1 = LOW_SURR_BASE | {6'd0, offset[9:0]};
         end
      end

      failed_in = failed_ff || fail_now;
      bad       = failed_in || (rem_in != 2'd0);

      push_entry.unit_count = count;
      if (in_last) begin
         push_entry.has_marker = 1'b1;
         push_entry.marker_err = bad;
         if (bad) begin
            push_entry.unit_count = 2'd0;
         end
         acc_in    = '0;
         rem_in    = '0;
         failed_in = 1'b0;
      end
   end

   assign push = accept && (in_last || (count != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         rem_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         acc_ff    <= acc_in;
         rem_ff    <= rem_in;
         failed_ff <= failed_in;
      end
   end

endmodule
`default_nettype wire

>>> src/u2u_queue.sv
// Small register queue of decoded entries between the front and back ends.
`default_nettype none
module u2u_queue import u2u_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  entry_type      push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           not_empty,
   output entry_type      head
);

   entry_type             slots_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]    count_ff, count_in;

   assign full      = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/u2u_back.sv
// Back end: steps through the results of the head entry, one per cycle while out_ready is high.
`default_nettype none
module u2u_back import u2u_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   head_valid,
   input  entry_type   head,
   output logic        pop,
   output logic        out_valid,
   input  wire logic   out_ready,
   output logic [15:0] out_unit,
   output logic [1:0]  out_status,
   output logic        out_last
);

   logic [1:0] idx_ff, idx_in;
   logic [1:0] total;
   logic       fire;

   assign total     = head.unit_count + {1'b0, head.has_marker};
   assign out_valid = head_valid;
   assign out_last  = (idx_ff == total - 2'd1);
   assign fire      = out_valid && out_ready;
   assign pop       = fire && out_last;

   always_comb begin
      if (idx_ff < head.unit_count) begin
         out_unit   = (idx_ff == 2'd0) ? head.unit0 : head.unit1;
         out_status = STATUS_UNIT;
      end else begin
         out_unit   = '0;
         out_status = head.marker_err ? STATUS_ERR : STATUS_OK;
      end
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire
